FILE: rtl/core/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [CountW-1:0] count_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_PRESS_DEB   = 3'd1,
		PH_PRESSED     = 3'd2,
		PH_WAIT_SECOND = 3'd3,
		PH_SECOND_DEB  = 3'd4,
		PH_WAIT_REL    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_DOUBLE_GAP = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam count_t DebounceReset  = 16'd2;
	localparam count_t LongPressReset = 16'd100;
	localparam count_t DoubleGapReset = 16'd30;

	typedef struct packed {
		count_t debounce_ticks;
		count_t long_press_ticks;
		count_t double_gap_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		event_t evt;
	} status_t;

endpackage

FILE: rtl/core/button_click_classifier_top.sv
// Top level of the button click classifier: stream ports, pipeline registers.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | s_tdata[0] key_pin_level (0 = pressed)
//  m_*      | out       | m_tdata[1:0] event_code (0 none/1 short/2 long/3 double)
//  cfg_*    | in        | cfg_index register number, cfg_data 16-bit value
//
// One item per cycle sustained while the output is not held; an accepted item
// passes the input register, then the result register, before output valid. The
// classifier state advances only when an item moves into the result register, so
// a stalled output holds the state. Reset clears the state, the valid bits and
// loads the register defaults; configuration writes are always taken.
module button_click_classifier_top
	import bcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] key_pin_level, [7:1] zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [1:0] event_code, [7:2] zero
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data
);

	logic    valid_s1;
	logic    key_s1;
	logic    valid_s2;
	event_t  event_s2;
	logic    adv_s2;
	cfg_t    cfg;
	status_t status;

	assign cfg_ready = 1'b1;

	bcc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (count_t'(cfg_data)),
		.cfg      (cfg)
	);

	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) key_s1 <= s_tdata[0];
	end

	bcc_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s2),
		.pressed (!key_s1),
		.cfg     (cfg),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) event_s2 <= status.evt;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, event_s2};

	// input side stalls only when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without a held output");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> m_tvalid)
		else $error("processed item did not reach the output register");

	a_long_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (status.evt == EV_LONG || status.evt == EV_DOUBLE))
		|=> status.phase == PH_WAIT_REL)
		else $error("long or double event not followed by release wait");

	a_short_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && status.evt == EV_SHORT) |=> status.phase == PH_IDLE)
		else $error("short event not followed by idle");

endmodule

FILE: rtl/core/bcc_regs.sv
// Configuration register file for the button click classifier.
module bcc_regs
	import bcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  count_t             wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DebounceReset;
			cfg_q.long_press_ticks <= LongPressReset;
			cfg_q.double_gap_ticks <= DoubleGapReset;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= wr_data;
				REG_LONG_PRESS: cfg_q.long_press_ticks <= wr_data;
				REG_DOUBLE_GAP: cfg_q.double_gap_ticks <= wr_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bcc_classify.sv
// Press classifier state machine with its tick counter.
module bcc_classify
	import bcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    pressed,
	input  cfg_t    cfg,
	output status_t status
);

	phase_t phase_q, phase_d;
	count_t count_q, count_d;
	count_t count_inc;
	count_t limit;
	logic   reached;
	event_t evt;

	// saturating increment, then compare against the threshold of this phase
	assign count_inc = (count_q == '1) ? count_q : count_q + count_t'(1);

	always_comb begin
		case (phase_q)
			PH_PRESS_DEB, PH_SECOND_DEB: limit = cfg.debounce_ticks;
			PH_PRESSED:                  limit = cfg.long_press_ticks;
			PH_WAIT_SECOND:              limit = cfg.double_gap_ticks;
			default:                     limit = '1;
		endcase
	end

	assign reached = (count_inc >= limit);

	// next state and counter
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					count_d = '0;
					phase_d = PH_PRESS_DEB;
				end
			end
			PH_PRESS_DEB: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
				end else if (reached) begin
					count_d = '0;
					phase_d = PH_PRESSED;
				end else begin
					count_d = count_inc;
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					count_d = '0;
					phase_d = PH_WAIT_SECOND;
				end else begin
					count_d = count_inc;
					if (reached) phase_d = PH_WAIT_REL;
				end
			end
			PH_WAIT_SECOND: begin
				if (pressed) begin
					count_d = '0;
					phase_d = PH_SECOND_DEB;
				end else begin
					count_d = count_inc;
					if (reached) phase_d = PH_IDLE;
				end
			end
			PH_SECOND_DEB: begin
				// a bounce goes back to the gap wait and keeps the count
				if (!pressed) begin
					phase_d = PH_WAIT_SECOND;
				end else begin
					count_d = count_inc;
					if (reached) phase_d = PH_WAIT_REL;
				end
			end
			PH_WAIT_REL: begin
				if (!pressed) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// event raised on this tick
	always_comb begin
		case (phase_q)
			PH_PRESSED:     evt = (pressed && reached) ? EV_LONG : EV_NONE;
			PH_WAIT_SECOND: evt = (!pressed && reached) ? EV_SHORT : EV_NONE;
			PH_SECOND_DEB:  evt = (pressed && reached) ? EV_DOUBLE : EV_NONE;
			default:        evt = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	assign status.phase = phase_q;
	assign status.evt   = evt;

endmodule

FILE: sim/tb.sv
// Testbench for button_click_classifier_top: scripted press patterns, then randomized scan streams.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcc_pkg::*;

	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned SettleCycles  = 6;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [0] key_pin_level, [7:1] zero
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // [1:0] event_code, [7:2] zero
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [15:0]        cfg_data;

	button_click_classifier_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Classifier state mirrored by the testbench
	phase_t      cur_phase = PH_IDLE;
	count_t      tick_cnt  = '0;
	count_t      deb_thr   = DebounceReset;
	count_t      long_thr  = LongPressReset;
	count_t      gap_thr   = DoubleGapReset;
	event_t      pending_events[$];
	int unsigned errors       = 0;
	int unsigned stall_cycles = 0;
	bit          no_gaps      = 1'b0;

	typedef struct {
		logic        key;
		int unsigned reps;
		bit          known;
		event_t      ev;
	} press_row_t;

	typedef struct {
		count_t      deb;
		count_t      lng;
		count_t      gap;
		int unsigned items;
		bit          calm;
	} setting_t;

	// Reset thresholds: debounce 2, long 100, gap 30. A typed event lands on the row's last tick.
	press_row_t press_script[] = '{
		'{1'b1,   2, 1'b1, EV_NONE},
		'{1'b0,   1, 1'b1, EV_NONE},    // bounce during press debounce
		'{1'b1,   1, 1'b1, EV_NONE},
		'{1'b0,   3, 1'b1, EV_NONE},
		'{1'b1,  31, 1'b1, EV_SHORT},   // gap window expires
		'{1'b0,   3, 1'b1, EV_NONE},
		'{1'b0, 100, 1'b1, EV_LONG},
		'{1'b0,   2, 1'b1, EV_NONE},    // hold until release
		'{1'b1,   1, 1'b1, EV_NONE},
		'{1'b0,   3, 1'b1, EV_NONE},
		'{1'b1,   5, 1'b1, EV_NONE},
		'{1'b0,   3, 1'b1, EV_DOUBLE},
		'{1'b1,   1, 1'b1, EV_NONE},
		'{1'b0,   3, 1'b1, EV_NONE},
		'{1'b1,  10, 1'b1, EV_NONE},
		'{1'b0,   2, 1'b1, EV_NONE},
		'{1'b1,  10, 1'b0, EV_NONE}     // bounce in second debounce keeps the count
	};

	setting_t settings[] = '{
		'{16'd1,     16'd1,     16'd1,     150, 1'b0},
		'{16'd3,     16'd12,    16'd6,     400, 1'b0},
		'{16'd2,     16'd25,    16'd10,    300, 1'b1},
		'{16'd0,     16'd0,     16'd0,      60, 1'b0},
		'{16'hFFFF,  16'hFFFF,  16'hFFFF,  100, 1'b0},
		'{16'd1,     16'd8,     16'hFFFF,  100, 1'b0}
	};

	function automatic bit count_reached(input count_t limit);
		if (tick_cnt != '1)
			tick_cnt++;
		return tick_cnt >= limit;
	endfunction

	function automatic event_t classify_tick(input logic key_level);
		logic   pressed;
		event_t ev;
		pressed = !key_level;
		ev = EV_NONE;
		case (cur_phase)
		PH_IDLE: if (pressed) begin
			tick_cnt = '0;
			cur_phase = PH_PRESS_DEB;
		end
		PH_PRESS_DEB: if (!pressed) begin
			cur_phase = PH_IDLE;
		end else if (count_reached(deb_thr)) begin
			tick_cnt = '0;
			cur_phase = PH_PRESSED;
		end
		PH_PRESSED: if (!pressed) begin
			tick_cnt = '0;
			cur_phase = PH_WAIT_SECOND;
		end else if (count_reached(long_thr)) begin
			ev = EV_LONG;
			cur_phase = PH_WAIT_REL;
		end
		PH_WAIT_SECOND: if (pressed) begin
			tick_cnt = '0;
			cur_phase = PH_SECOND_DEB;
		end else if (count_reached(gap_thr)) begin
			ev = EV_SHORT;
			cur_phase = PH_IDLE;
		end
		PH_SECOND_DEB: if (!pressed) begin
			cur_phase = PH_WAIT_SECOND;
		end else if (count_reached(deb_thr)) begin
			ev = EV_DOUBLE;
			cur_phase = PH_WAIT_REL;
		end
		PH_WAIT_REL: if (!pressed) begin
			cur_phase = PH_IDLE;
		end
		default: cur_phase = PH_IDLE;
		endcase
		return ev;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic send_key(input logic key_level, input bit typed, input event_t typed_ev);
		event_t predicted;
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			repeat (pick_gap()) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, key_level};
		do @(posedge clk); while (!s_tready);
		predicted = classify_tick(key_level);
		pending_events.push_back(typed ? typed_ev : predicted);
	endtask

	task automatic quiet_source();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input count_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_DEBOUNCE:   deb_thr = value;
		REG_LONG_PRESS: long_thr = value;
		REG_DOUBLE_GAP: gap_thr = value;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Alternate press and release runs sized around the thresholds, with bounces and noise
	task automatic random_ticks(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		int unsigned span;
		logic        level;
		sent = 0;
		level = 1'b1;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				run_len = $urandom_range(1, 8);
				repeat (run_len) begin
					level = logic'($urandom_range(0, 1));
					send_key(level, 1'b0, EV_NONE);
					sent++;
				end
			end else begin
				level = ~level;
				if ($urandom_range(0, 6) == 0) begin
					run_len = $urandom_range(1, 2);
				end else begin
					span = level ? int'(gap_thr) : int'(long_thr) + int'(deb_thr);
					if (span > 60)
						span = 60;
					run_len = $urandom_range(1, span + 3);
				end
				repeat (run_len) begin
					send_key(level, 1'b0, EV_NONE);
					sent++;
				end
			end
			// hold off now and then until every result is back
			if ($urandom_range(0, 60) == 0) begin
				quiet_source();
				wait_drained();
			end
		end
		quiet_source();
	endtask

	initial begin
		int unsigned hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 4) == 0)
					hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("result with nothing pending, m_tdata", m_tdata, -1);
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[1:0] != want)
					report_mismatch("event_code", m_tdata[1:0], want);
				if (m_tdata[7:2] != '0)
					report_mismatch("m_tdata padding", m_tdata[7:2], 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WatchdogLimit) begin
			$display("[button_click_classifier_top] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (press_script[i]) begin
			for (int r = 0; r < press_script[i].reps; r++)
				send_key(press_script[i].key, press_script[i].known,
					(r == press_script[i].reps - 1) ? press_script[i].ev : EV_NONE);
		end
		quiet_source();
		settle();

		foreach (settings[p]) begin
			write_reg(REG_DEBOUNCE, settings[p].deb);
			write_reg(REG_LONG_PRESS, settings[p].lng);
			write_reg(REG_DOUBLE_GAP, settings[p].gap);
			write_reg(REG_UNUSED, count_t'($urandom));
			no_gaps = settings[p].calm;
			random_ticks(settings[p].items);
			settle();
		end
		no_gaps = 1'b0;

		// Lower the long threshold below a count already in progress
		write_reg(REG_DEBOUNCE, 16'd4);
		write_reg(REG_LONG_PRESS, 16'd40);
		write_reg(REG_DOUBLE_GAP, 16'd15);
		repeat (2) send_key(1'b1, 1'b0, EV_NONE);
		repeat (15) send_key(1'b0, 1'b0, EV_NONE);
		quiet_source();
		settle();
		write_reg(REG_LONG_PRESS, 16'd3);
		repeat (3) send_key(1'b0, 1'b0, EV_NONE);
		quiet_source();
		settle();
		write_reg(REG_LONG_PRESS, 16'd40);
		random_ticks(300);
		settle();

		if (errors == 0)
			$display("[button_click_classifier_top] OK");
		else
			$display("[button_click_classifier_top] ERROR");
		$finish;
	end

endmodule
